// File: rtl/core/stdir_pkg.sv
// shared constants, codes and types of the string table directory
`timescale 1ns / 1ps
package stdir_pkg;

   // parameter defaults
   localparam int MAX_BLOBS_DEF         = 4;
   localparam int MAX_TXTS_PER_BLOB_DEF = 64;
   localparam int OFFSET_BITS_DEF       = 16;

   // count registers that exist in the register map
   localparam int NUM_COUNT_REGS = 4;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 7;
   localparam int NUM_BLOBS_W = 3;
   localparam int TXTS_W      = 7;

   // result field widths
   localparam int TEXT_COUNT_W  = 7;
   localparam int TEXT_OFFSET_W = 16;
   localparam int TEXT_LENGTH_W = 8;
   localparam int BLOB_FOUND_W  = 2;

   // string terminator
   localparam logic [7:0] STR_END = 8'h00;

   // register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_BLOBS = 3'd0,
      CSR_TXTS_0    = 3'd1,
      CSR_TXTS_1    = 3'd2,
      CSR_TXTS_2    = 3'd3,
      CSR_TXTS_3    = 3'd4
   } csr_index_type;

   // item function codes
   typedef enum logic {
      FUNC_LOAD   = 1'b0,
      FUNC_LOOKUP = 1'b1
   } func_type;

   // result kinds
   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_LOOKUP = 1'b1
   } kind_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_RANGE    = 2'd1,
      ST_OVERFLOW = 2'd2,
      ST_BAD_BLOB = 2'd3
   } status_type;

endpackage

// File: rtl/core/stdir_req_if.sv
// request channel: load bytes and lookups
`timescale 1ns / 1ps
interface stdir_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic       first_byte;
   logic [1:0] blob_select;
   logic [7:0] byte_value;
   logic [7:0] text_id;

   modport source (output valid, func, first_byte, blob_select, byte_value, text_id,
                   input ready);
   modport sink (input valid, func, first_byte, blob_select, byte_value, text_id,
                 output ready);
endinterface

// File: rtl/core/stdir_rsp_if.sv
// response channel: load completions and lookup answers
`timescale 1ns / 1ps
interface stdir_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [1:0]  status;
   logic [6:0]  text_count;
   logic [1:0]  blob_found;
   logic [15:0] text_offset;
   logic [7:0]  text_length;

   modport source (output valid, result_kind, status, text_count, blob_found, text_offset,
                   text_length, input ready);
   modport sink (input valid, result_kind, status, text_count, blob_found, text_offset,
                 text_length, output ready);
endinterface

// File: rtl/core/stdir_ram.sv
// generic synchronous ram: one write port, two registered read ports
`timescale 1ns / 1ps
module stdir_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 260,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr_a,
   input  logic [ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]  rdata_a,
   output logic [WIDTH-1:0]  rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   // write port and registered reads
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// File: rtl/core/stdir_csr.sv
// configuration registers and clamped per-blob counts
`timescale 1ns / 1ps
module stdir_csr #(
   parameter int MAX_BLOBS         = 4,
   parameter int MAX_TXTS_PER_BLOB = 64,
   localparam int NB_W  = $clog2(MAX_BLOBS + 1),
   localparam int CNT_W = $clog2(MAX_TXTS_PER_BLOB + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [stdir_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [stdir_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic [NB_W-1:0]                        nb_use,
   output logic [MAX_BLOBS-1:0][CNT_W-1:0]        blob_cnt
);
   import stdir_pkg::*;

   logic [NUM_BLOBS_W-1:0] num_blobs_ff, num_blobs_in;
   logic [TXTS_W-1:0]      txts_ff [NUM_COUNT_REGS];
   logic [TXTS_W-1:0]      txts_in [NUM_COUNT_REGS];

   // register write decode
   always_comb begin
      num_blobs_in = num_blobs_ff;
      for (int i = 0; i < NUM_COUNT_REGS; i++) begin
         txts_in[i] = txts_ff[i];
      end
      if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_BLOBS: num_blobs_in = csr_wdata[NUM_BLOBS_W-1:0];
            CSR_TXTS_0:    txts_in[0]   = csr_wdata[TXTS_W-1:0];
            CSR_TXTS_1:    txts_in[1]   = csr_wdata[TXTS_W-1:0];
            CSR_TXTS_2:    txts_in[2]   = csr_wdata[TXTS_W-1:0];
            CSR_TXTS_3:    txts_in[3]   = csr_wdata[TXTS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_blobs_ff <= NUM_BLOBS_W'(1);
         for (int i = 0; i < NUM_COUNT_REGS; i++) begin
            txts_ff[i] <= TXTS_W'(1);
         end
      end else begin
         num_blobs_ff <= num_blobs_in;
         for (int i = 0; i < NUM_COUNT_REGS; i++) begin
            txts_ff[i] <= txts_in[i];
         end
      end
   end

   // blobs in use, limited to the directory size
   always_comb begin
      if (int'(num_blobs_ff) > MAX_BLOBS) begin
         nb_use = NB_W'(MAX_BLOBS);
      end else begin
         nb_use = NB_W'(num_blobs_ff);
      end
   end

   // per-blob counts, limited; blobs without a register count zero
   for (genvar b = 0; b < MAX_BLOBS; b++) begin : g_cnt
      if (b < NUM_COUNT_REGS) begin : g_reg
         assign blob_cnt[b] = (int'(txts_ff[b]) > MAX_TXTS_PER_BLOB) ?
                              CNT_W'(MAX_TXTS_PER_BLOB) : CNT_W'(txts_ff[b]);
      end else begin : g_none
         assign blob_cnt[b] = '0;
      end
   end

endmodule

// File: rtl/core/stdir_engine.sv
// item slot, blob loader, lookup sequencer, directory clearing and result register
`timescale 1ns / 1ps
module stdir_engine #(
   parameter int MAX_BLOBS         = 4,
   parameter int MAX_TXTS_PER_BLOB = 64,
   parameter int OFFSET_BITS       = 16,
   localparam int NB_W   = $clog2(MAX_BLOBS + 1),
   localparam int CNT_W  = $clog2(MAX_TXTS_PER_BLOB + 1),
   localparam int STRIDE = MAX_TXTS_PER_BLOB + 1,
   localparam int DEPTH  = MAX_BLOBS * STRIDE,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            reset,
   stdir_req_if.sink                       req_ch,
   stdir_rsp_if.source                     rsp_ch,
   input  logic [NB_W-1:0]                 nb_use,
   input  logic [MAX_BLOBS-1:0][CNT_W-1:0] blob_cnt,
   output logic                            dir_we,
   output logic [ADDR_W-1:0]               dir_waddr,
   output logic [OFFSET_BITS-1:0]          dir_wdata,
   output logic [ADDR_W-1:0]               dir_raddr_a,
   output logic [ADDR_W-1:0]               dir_raddr_b,
   input  logic [OFFSET_BITS-1:0]          dir_rdata_a,
   input  logic [OFFSET_BITS-1:0]          dir_rdata_b
);
   import stdir_pkg::*;

   localparam int BSEL_W = (MAX_BLOBS > 1) ? $clog2(MAX_BLOBS) : 1;
   localparam int SUM_W  = $clog2(MAX_BLOBS * MAX_TXTS_PER_BLOB + 1);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_RUN,
      S_LK_RD,
      S_LK_OUT
   } state_type;

   // control state
   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;
   logic              slot_full_ff, slot_full_in;
   logic              start_ff, start_in;
   logic              ovf_ff, ovf_in;
   logic [OFFSET_BITS-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // held item
   logic              slot_func_ff, slot_func_in;
   logic              slot_first_ff, slot_first_in;
   logic [1:0]        slot_sel_ff, slot_sel_in;
   logic [7:0]        slot_byte_ff, slot_byte_in;
   logic [7:0]        slot_id_ff, slot_id_in;

   // lookup mapping
   logic              lk_hit_ff, lk_hit_in;
   logic [BSEL_W-1:0] lk_blob_ff, lk_blob_in;
   logic [CNT_W-1:0]  lk_local_ff, lk_local_in;

   // result payload
   logic                     rsp_kind_ff, rsp_kind_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [TEXT_COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [BLOB_FOUND_W-1:0]  rsp_blob_ff, rsp_blob_in;
   logic [TEXT_OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [TEXT_LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   // working signals
   logic                   out_free;
   logic                   accept;
   logic                   sel_ok;
   logic [CNT_W-1:0]       cnt_sel;
   logic [OFFSET_BITS-1:0] pos_e;
   logic [CNT_W-1:0]       idx_e;
   logic                   start_e;
   logic                   ovf_e;
   logic                   is_end;
   logic                   load_result;
   logic                   run_load;
   logic                   run_lookup;
   logic                   load_go;
   logic                   lk_done;
   logic                   slot_done;
   logic                   map_found;
   logic [BSEL_W-1:0]      map_blob;
   logic [CNT_W-1:0]       map_local;
   logic [SUM_W-1:0]       map_below;
   logic [ADDR_W-1:0]      lk_base;
   logic [OFFSET_BITS-1:0] lk_diff;

   // handshake
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign run_load     = (state_ff == S_RUN) && slot_full_ff && (slot_func_ff == FUNC_LOAD);
   assign run_lookup   = (state_ff == S_RUN) && slot_full_ff && (slot_func_ff == FUNC_LOOKUP);
   assign load_go      = run_load && (!load_result || out_free);
   assign lk_done      = (state_ff == S_LK_OUT) && out_free;
   assign slot_done    = load_go || lk_done;
   assign req_ch.ready = (state_ff != S_CLEAR) && (!slot_full_ff || slot_done);

   // blob select check and its count
   always_comb begin
      sel_ok  = int'(slot_sel_ff) < int'(nb_use);
      cnt_sel = '0;
      for (int b = 0; b < MAX_BLOBS; b++) begin
         if (sel_ok && (int'(slot_sel_ff) == b)) begin
            cnt_sel = blob_cnt[b];
         end
      end
   end

   // loader state as seen by this byte, after a first-byte restart
   always_comb begin
      if (slot_first_ff) begin
         pos_e   = '0;
         idx_e   = '0;
         start_e = 1'b1;
         ovf_e   = 1'b0;
      end else begin
         pos_e   = pos_ff;
         idx_e   = idx_ff;
         start_e = start_ff;
         ovf_e   = ovf_ff;
      end
      is_end      = slot_byte_ff == STR_END;
      load_result = start_e && is_end;
   end

   // global text number to blob and local index
   always_comb begin
      map_found = 1'b0;
      map_blob  = '0;
      map_local = '0;
      map_below = '0;
      for (int b = 0; b < MAX_BLOBS; b++) begin
         if (!map_found && (b < int'(nb_use)) &&
             (int'(slot_id_ff) < int'(map_below) + int'(blob_cnt[b]))) begin
            map_found = 1'b1;
            map_blob  = BSEL_W'(b);
            map_local = CNT_W'(int'(slot_id_ff) - int'(map_below));
         end
         map_below = SUM_W'(int'(map_below) + int'(blob_cnt[b]));
      end
   end

   // directory reads for a lookup: this text's start and the next one
   assign lk_base     = ADDR_W'(int'(lk_blob_ff) * STRIDE + int'(lk_local_ff));
   assign dir_raddr_a = lk_base;
   assign dir_raddr_b = ADDR_W'(int'(lk_base) + 1);
   assign lk_diff     = dir_rdata_b - dir_rdata_a - OFFSET_BITS'(1);

   // directory write: clearing sweep or string start
   always_comb begin
      if (state_ff == S_CLEAR) begin
         dir_we    = 1'b1;
         dir_waddr = clr_addr_ff;
         dir_wdata = '0;
      end else begin
         dir_we    = load_go && start_e && sel_ok && !ovf_e && (idx_e <= cnt_sel);
         dir_waddr = ADDR_W'(int'(slot_sel_ff) * STRIDE + int'(idx_e));
         dir_wdata = pos_e;
      end
   end

   // next state
   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      slot_full_in  = slot_full_ff;
      start_in      = start_ff;
      ovf_in        = ovf_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;

      slot_func_in  = slot_func_ff;
      slot_first_in = slot_first_ff;
      slot_sel_in   = slot_sel_ff;
      slot_byte_in  = slot_byte_ff;
      slot_id_in    = slot_id_ff;

      lk_hit_in     = lk_hit_ff;
      lk_blob_in    = lk_blob_ff;
      lk_local_in   = lk_local_ff;

      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_blob_in   = rsp_blob_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_length_in = rsp_length_ff;

      // item slot
      if (accept) begin
         slot_full_in  = 1'b1;
         slot_func_in  = req_ch.func;
         slot_first_in = req_ch.first_byte;
         slot_sel_in   = req_ch.blob_select;
         slot_byte_in  = req_ch.byte_value;
         slot_id_in    = req_ch.text_id;
      end else if (slot_done) begin
         slot_full_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_RUN;
            end else begin
               clr_addr_in = clr_addr_ff + ADDR_W'(1);
            end
         end
         S_RUN: begin
            // one load byte per cycle; a blob-completing byte waits for the response register
            if (load_go) begin
               if (start_e) begin
                  if (is_end) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = KIND_LOAD;
                     rsp_status_in = !sel_ok ? ST_BAD_BLOB :
                                     (ovf_e ? ST_OVERFLOW : ST_OK);
                     rsp_count_in  = sel_ok ? TEXT_COUNT_W'(idx_e) : '0;
                     rsp_blob_in   = '0;
                     rsp_offset_in = '0;
                     rsp_length_in = '0;
                     pos_in        = '0;
                     idx_in        = '0;
                     start_in      = 1'b1;
                     ovf_in        = 1'b0;
                  end else begin
                     ovf_in   = ovf_e || (idx_e >= cnt_sel);
                     start_in = 1'b0;
                     idx_in   = idx_e;
                     pos_in   = pos_e + OFFSET_BITS'(1);
                  end
               end else begin
                  start_in = is_end;
                  ovf_in   = ovf_e;
                  idx_in   = (is_end && !ovf_e) ? idx_e + CNT_W'(1) : idx_e;
                  pos_in   = pos_e + OFFSET_BITS'(1);
               end
            end
            // lookup: register the mapping
            if (run_lookup) begin
               lk_hit_in   = map_found;
               lk_blob_in  = map_blob;
               lk_local_in = map_local;
               state_in    = S_LK_RD;
            end
         end
         S_LK_RD: begin
            state_in = S_LK_OUT;
         end
         S_LK_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_LOOKUP;
               rsp_count_in  = '0;
               if (lk_hit_ff) begin
                  rsp_status_in = ST_OK;
                  rsp_blob_in   = BLOB_FOUND_W'(lk_blob_ff);
                  rsp_offset_in = TEXT_OFFSET_W'(dir_rdata_a);
                  rsp_length_in = lk_diff[TEXT_LENGTH_W-1:0];
               end else begin
                  rsp_status_in = ST_RANGE;
                  rsp_blob_in   = '0;
                  rsp_offset_in = '0;
                  rsp_length_in = '0;
               end
               state_in = S_RUN;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      slot_func_ff  <= slot_func_in;
      slot_first_ff <= slot_first_in;
      slot_sel_ff   <= slot_sel_in;
      slot_byte_ff  <= slot_byte_in;
      slot_id_ff    <= slot_id_in;
      lk_hit_ff     <= lk_hit_in;
      lk_blob_ff    <= lk_blob_in;
      lk_local_ff   <= lk_local_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_blob_ff   <= rsp_blob_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         slot_full_ff <= 1'b0;
         start_ff     <= 1'b1;
         ovf_ff       <= 1'b0;
         pos_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         slot_full_ff <= slot_full_in;
         start_ff     <= start_in;
         ovf_ff       <= ovf_in;
         pos_ff       <= pos_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result channel
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.text_count  = rsp_count_ff;
   assign rsp_ch.blob_found  = rsp_blob_ff;
   assign rsp_ch.text_offset = rsp_offset_ff;
   assign rsp_ch.text_length = rsp_length_ff;

endmodule

// File: rtl/core/string_table_directory_top.sv
// top level of the string table directory
`timescale 1ns / 1ps
// The block indexes up to MAX_BLOBS blobs of zero-terminated strings held in
// one directory ram of MAX_BLOBS*(MAX_TXTS_PER_BLOB+1) words of OFFSET_BITS.
// After reset a clearing pass writes zero to every directory word, one word a
// cycle; req_ch.ready stays low until it ends, while csr writes are taken at
// once. An accepted item sits in a one-item slot; a load byte is processed in
// the next cycle, so a blob streams at one byte per cycle, and the byte that
// completes a blob waits only for the response register to free up. A lookup
// goes through three steps after acceptance: mapping the text number onto a
// blob, the two-word read of the directory ram, and the length calculation
// into the response register once it is free. The response register lets the
// next item be accepted while a result is still pending.
module string_table_directory_top #(
   parameter int MAX_BLOBS         = stdir_pkg::MAX_BLOBS_DEF,
   parameter int MAX_TXTS_PER_BLOB = stdir_pkg::MAX_TXTS_PER_BLOB_DEF,
   parameter int OFFSET_BITS       = stdir_pkg::OFFSET_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   stdir_req_if.sink                         req_ch,
   stdir_rsp_if.source                       rsp_ch,
   input  logic                              csr_we,
   input  logic [stdir_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [stdir_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NB_W   = $clog2(MAX_BLOBS + 1);
   localparam int CNT_W  = $clog2(MAX_TXTS_PER_BLOB + 1);
   localparam int STRIDE = MAX_TXTS_PER_BLOB + 1;
   localparam int DEPTH  = MAX_BLOBS * STRIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [NB_W-1:0]                 nb_use;
   logic [MAX_BLOBS-1:0][CNT_W-1:0] blob_cnt;
   logic                            dir_we;
   logic [ADDR_W-1:0]               dir_waddr;
   logic [OFFSET_BITS-1:0]          dir_wdata;
   logic [ADDR_W-1:0]               dir_raddr_a;
   logic [ADDR_W-1:0]               dir_raddr_b;
   logic [OFFSET_BITS-1:0]          dir_rdata_a;
   logic [OFFSET_BITS-1:0]          dir_rdata_b;

   // configuration registers
   stdir_csr #(
      .MAX_BLOBS         (MAX_BLOBS),
      .MAX_TXTS_PER_BLOB (MAX_TXTS_PER_BLOB)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .nb_use    (nb_use),
      .blob_cnt  (blob_cnt)
   );

   // directory store
   stdir_ram #(
      .WIDTH (OFFSET_BITS),
      .DEPTH (DEPTH)
   ) u_dir_ram (
      .clock   (clock),
      .we      (dir_we),
      .waddr   (dir_waddr),
      .wdata   (dir_wdata),
      .raddr_a (dir_raddr_a),
      .raddr_b (dir_raddr_b),
      .rdata_a (dir_rdata_a),
      .rdata_b (dir_rdata_b)
   );

   // load and lookup control
   stdir_engine #(
      .MAX_BLOBS         (MAX_BLOBS),
      .MAX_TXTS_PER_BLOB (MAX_TXTS_PER_BLOB),
      .OFFSET_BITS       (OFFSET_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .nb_use      (nb_use),
      .blob_cnt    (blob_cnt),
      .dir_we      (dir_we),
      .dir_waddr   (dir_waddr),
      .dir_wdata   (dir_wdata),
      .dir_raddr_a (dir_raddr_a),
      .dir_raddr_b (dir_raddr_b),
      .dir_rdata_a (dir_rdata_a),
      .dir_rdata_b (dir_rdata_b)
   );

endmodule
